[src/kbt_pkg.sv]
// ----------------------------------------------------------------------------
// kbt_pkg: shared types and constants of the keyed balance table
// Sizes of the table, result status codes and the job record that the
// classifier hands to the balance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kbt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int BAL_W   = 64;

    // job queue between classifier and balance unit
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic {
        OP_APPLY = 1'b0,
        OP_GET   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        CLS_GET_HIT,
        CLS_GET_MISS,
        CLS_APPLY,
        CLS_EMPTY,
        CLS_FULL
    } cls_t;

    typedef struct packed {
        cls_t                     cls;
        logic                     is_new;
        logic [IDX_W-1:0]         slot;
        logic signed [BAL_W-1:0]  delta;
    } job_t;

    // queue port status toward its two sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    typedef enum logic {
        BK_FETCH,
        BK_EXEC
    } bk_state_t;

endpackage

`default_nettype wire

[src/kbt_if.sv]
// ----------------------------------------------------------------------------
// kbt_if: request and response channels of the keyed balance table
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface kbt_req_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [kbt_pkg::KEY_W-1:0]          key_code;
    logic signed [kbt_pkg::BAL_W-1:0]   delta;

    modport source (output valid, output operation, output key_code, output delta,
                    input ready);
    modport sink   (input valid, input operation, input key_code, input delta,
                    output ready);
endinterface

interface kbt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic signed [kbt_pkg::BAL_W-1:0]   balance;

    modport source (output valid, output status, output balance, input ready);
    modport sink   (input valid, input status, input balance, output ready);
endinterface

`default_nettype wire

[src/kbt_front.sv]
// ----------------------------------------------------------------------------
// kbt_front: request classifier
// Match the key against the occupied entries, allocate new entries and
// push one job per request into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kbt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    kbt_req_if.sink                req,
    input  wire kbt_pkg::q_stat_t  q_stat,
    output logic                   push,
    output kbt_pkg::job_t          job
);

    logic [kbt_pkg::KEY_W-1:0] key_reg [kbt_pkg::ENTRIES];
    logic [kbt_pkg::CNT_W-1:0] count_reg;
    logic [kbt_pkg::CNT_W-1:0] count_next;

    logic                      hit;
    logic [kbt_pkg::IDX_W-1:0] hit_slot;
    logic                      table_full;
    logic                      empty_key;
    logic                      alloc;

    // keys are unique, so at most one entry matches
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = 0; i < kbt_pkg::ENTRIES; i++)
        begin
            if ((kbt_pkg::CNT_W'(i) < count_reg) && (key_reg[i] == req.key_code))
            begin
                hit      = 1'b1;
                hit_slot = hit_slot | kbt_pkg::IDX_W'(i);
            end
        end
    end

    assign table_full = (count_reg >= kbt_pkg::CNT_W'(kbt_pkg::ENTRIES));
    assign empty_key  = (req.key_code[7:0] == 8'd0);

    always_comb
    begin
        job.delta  = req.delta;
        job.is_new = 1'b0;
        job.slot   = hit_slot;
        if (req.operation == kbt_pkg::OP_GET)
        begin
            job.cls = hit ? kbt_pkg::CLS_GET_HIT : kbt_pkg::CLS_GET_MISS;
        end
        else if (empty_key)
        begin
            job.cls = kbt_pkg::CLS_EMPTY;
        end
        else if (hit)
        begin
            job.cls = kbt_pkg::CLS_APPLY;
        end
        else if (table_full)
        begin
            job.cls = kbt_pkg::CLS_FULL;
        end
        else
        begin
            job.cls    = kbt_pkg::CLS_APPLY;
            job.is_new = 1'b1;
            job.slot   = count_reg[kbt_pkg::IDX_W-1:0];
        end
    end

    assign req.ready  = !q_stat.full;
    assign push       = req.valid && !q_stat.full;
    assign alloc      = push && (job.cls == kbt_pkg::CLS_APPLY) && job.is_new;
    assign count_next = alloc ? (count_reg + kbt_pkg::CNT_W'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            key_reg[count_reg[kbt_pkg::IDX_W-1:0]] <= req.key_code;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kbt_pkg::CNT_W'(kbt_pkg::ENTRIES))
        else $error("entry count beyond table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + kbt_pkg::CNT_W'(1)))
        else $error("entry count moved by other than one");
`endif

endmodule

`default_nettype wire

[src/kbt_queue.sv]
// ----------------------------------------------------------------------------
// kbt_queue: job queue
// Short first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module kbt_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire kbt_pkg::job_t     push_job,
    input  wire logic              pop,
    output kbt_pkg::job_t          pop_job,
    output kbt_pkg::q_stat_t       q_stat
);

    kbt_pkg::job_t              slot_reg [kbt_pkg::QDEPTH];
    logic [kbt_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [kbt_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [kbt_pkg::QCNT_W-1:0] cnt_reg;
    logic [kbt_pkg::QCNT_W-1:0] cnt_next;

    assign q_stat.full      = (cnt_reg == kbt_pkg::QCNT_W'(kbt_pkg::QDEPTH));
    assign q_stat.not_empty = (cnt_reg != '0);
    assign pop_job          = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + kbt_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - kbt_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + kbt_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + kbt_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full) && !(pop && !q_stat.not_empty))
        else $error("job queue pushed when full or popped when empty");
`endif

endmodule

`default_nettype wire

[src/kbt_back.sv]
// ----------------------------------------------------------------------------
// kbt_back: balance unit
// Read a job's entry balance; for an apply job add the delta with overflow
// check, write back if no overflow, and load the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module kbt_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kbt_pkg::q_stat_t  q_stat,
    input  wire kbt_pkg::job_t     q_job,
    output logic                   pop,
    kbt_rsp_if.source              rsp
);

    logic signed [kbt_pkg::BAL_W-1:0] bal_mem [kbt_pkg::ENTRIES];

    kbt_pkg::bk_state_t               state_reg;
    kbt_pkg::bk_state_t               state_next;
    kbt_pkg::job_t                    job_reg;
    logic signed [kbt_pkg::BAL_W-1:0] rd_data_reg;

    logic                             out_valid_reg;
    kbt_pkg::status_t                 out_status_reg;
    logic signed [kbt_pkg::BAL_W-1:0] out_bal_reg;

    logic                             out_free;
    logic                             commit;
    logic signed [kbt_pkg::BAL_W-1:0] base;
    logic signed [kbt_pkg::BAL_W-1:0] sum;
    logic                             ovf;
    logic                             mem_we;
    kbt_pkg::status_t                 res_status;
    logic signed [kbt_pkg::BAL_W-1:0] res_bal;

    assign out_free = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kbt_pkg::BK_FETCH:
            begin
                if (q_stat.not_empty)
                begin
                    state_next = kbt_pkg::BK_EXEC;
                end
            end
            kbt_pkg::BK_EXEC:
            begin
                if (out_free)
                begin
                    state_next = kbt_pkg::BK_FETCH;
                end
            end
            default:
            begin
                state_next = kbt_pkg::BK_FETCH;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop    = 1'b0;
        commit = 1'b0;
        case (state_reg)
            kbt_pkg::BK_FETCH:
            begin
                pop = q_stat.not_empty;
            end
            kbt_pkg::BK_EXEC:
            begin
                commit = out_free;
            end
            default:
            begin
                pop    = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    // a fresh entry starts from zero
    assign base = job_reg.is_new ? '0 : rd_data_reg;
    assign sum  = base + job_reg.delta;
    assign ovf  = (base[kbt_pkg::BAL_W-1] == job_reg.delta[kbt_pkg::BAL_W-1]) &&
                  (sum[kbt_pkg::BAL_W-1] != base[kbt_pkg::BAL_W-1]);

    always_comb
    begin
        res_status = kbt_pkg::ST_OK;
        res_bal    = '0;
        case (job_reg.cls)
            kbt_pkg::CLS_GET_HIT:
            begin
                res_bal = rd_data_reg;
            end
            kbt_pkg::CLS_GET_MISS:
            begin
                res_bal = '0;
            end
            kbt_pkg::CLS_EMPTY:
            begin
                res_status = kbt_pkg::ST_EMPTY;
            end
            kbt_pkg::CLS_FULL:
            begin
                res_status = kbt_pkg::ST_FULL;
            end
            kbt_pkg::CLS_APPLY:
            begin
                if (ovf)
                begin
                    res_status = kbt_pkg::ST_OVERFLOW;
                    res_bal    = base;
                end
                else
                begin
                    res_bal = sum;
                end
            end
            default:
            begin
                res_status = kbt_pkg::ST_OK;
                res_bal    = '0;
            end
        endcase
    end

    assign mem_we = commit && (job_reg.cls == kbt_pkg::CLS_APPLY) && !ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kbt_pkg::BK_FETCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg     <= q_job;
            rd_data_reg <= bal_mem[q_job.slot];
        end
        if (mem_we)
        begin
            bal_mem[job_reg.slot] <= sum;
        end
        if (commit)
        begin
            out_status_reg <= res_status;
            out_bal_reg    <= res_bal;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.balance = out_bal_reg;

`ifndef SYNTH
    a_load_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == kbt_pkg::BK_EXEC))
        else $error("response loaded outside the execute step");
`endif

endmodule

`default_nettype wire

[src/keyed_balance_table.sv]
// ----------------------------------------------------------------------------
// keyed_balance_table: bounded table of signed 64-bit balances
// Top level: classifier, job queue and balance unit.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: operation (0 apply delta, 1 read balance),
//   key_code and delta. A request is taken at a clock edge with valid and
//   ready high. rsp returns exactly one result per request, in order:
//   status (0 ok, 1 empty key, 2 table full, 3 overflow) and balance.
//   A request passes through the job queue, the balance unit's job
//   register and the response register. The balance unit takes a new job
//   only after the last one is through: a read step of the balance memory,
//   then its add and write-back step.
//   The classifier keeps the keys and the entry count and takes a request
//   in the cycle it arrives; the two-deep job queue lets it run ahead of
//   the balance unit, so up to three requests are taken while a response
//   waits on a stalled receiver (one held in the balance unit, two in the
//   queue). When the queue fills, req.ready drops.
//   Reset empties the table (entry count zero), the queue and the response
//   register; no clearing pass is needed, entries are written on first use.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_balance_table (
    input  wire logic clk,
    input  wire logic rst_n,
    kbt_req_if.sink   req,
    kbt_rsp_if.source rsp
);

    // classifier to queue
    logic              push;
    kbt_pkg::job_t     push_job;
    // queue to balance unit
    logic              pop;
    kbt_pkg::job_t     pop_job;
    kbt_pkg::q_stat_t  q_stat;

    // classify each request and allocate new entries
    kbt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_stat (q_stat),
        .push   (push),
        .job    (push_job)
    );

    // hold classified jobs until the balance unit takes them
    kbt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    // read, update and write back the balance; drive the response
    kbt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_job  (pop_job),
        .pop    (pop),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire
